// ===== rtl/nfa_sr_pkg.sv =====
`default_nettype none

package nfa_sr_pkg;

  // Table geometry
  localparam int STATES  = 32;
  localparam int SLOTS   = 8;
  localparam int STATE_W = $clog2(STATES);
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int ADDR_W  = STATE_W + SLOT_W;
  localparam int DEPTH   = STATES * SLOTS;
  localparam int CNT_W   = ADDR_W + 1;

  // Field widths fixed by the interface
  localparam int NUM_W  = 6;
  localparam int SYM_W  = 8;
  localparam int NEXT_W = 5;
  localparam int ESTA_W = 5;
  localparam int ESLT_W = 3;

  localparam logic [NUM_W-1:0] NUM_STATES_RST = NUM_W'(32);

  typedef logic [1:0] opcode_t;

  localparam opcode_t OP_WRITE = 2'd0;
  localparam opcode_t OP_START = 2'd1;
  localparam opcode_t OP_FEED  = 2'd2;
  localparam opcode_t OP_END   = 2'd3;

  localparam logic REG_NUM_STATES = 1'b0;

  typedef struct packed {
    opcode_t             opcode;
    logic [ESTA_W-1:0]   entry_state;
    logic [ESLT_W-1:0]   entry_slot;
    logic                entry_valid;
    logic [SYM_W-1:0]    entry_symbol;
    logic [NEXT_W-1:0]   entry_next;
    logic [SYM_W-1:0]    input_byte;
  } in_item_t;

  typedef struct packed {
    logic moved;
    logic alive;
    logic accepted;
    logic final_result;
  } out_item_t;

  typedef struct packed {
    logic [SYM_W-1:0]  symbol;
    logic [NEXT_W-1:0] next;
  } tbl_entry_t;

endpackage

`default_nettype wire

// ===== rtl/nfa_string_recognizer_top.sv =====
`default_nettype none

// NFA string recognizer.
// Items arrive on cmd, taken at a clock edge where start is high and busy low.
// Every item yields exactly one result on result, marked by done for one cycle,
// in the cycle after the item finishes; the receiver cannot stall it.
// Opcodes: table write, start string, feed symbol, end string.
// Write, start and end items finish in the accept cycle: done follows in the
// next cycle and busy stays low, so these can be issued every cycle.
// A feed symbol on a live string scans the transition table held in a
// synchronous RAM with one write and one registered read port, one entry per
// cycle, over all slots of the first num_states states. busy stays high through
// the scan and a final step that folds in the last read; done follows in the
// cycle after that step. A feed on a dead string finishes in the accept cycle.
// Entry valid bits live in flip-flops and clear at reset, so the table is
// usable at once; no clearing pass. Reset (rst, synchronous) also leaves state
// 0 as the only active state, the string alive and num_states at 32.
// num_states is to be written over the APB port at address 0 while idle; the
// block does not enforce this. pready is always high. Values 0 and above
// STATES are clamped to 1 and STATES.
module nfa_string_recognizer_top (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    start,
  output logic                   busy,
  input  nfa_sr_pkg::in_item_t   cmd,
  output logic                   done,
  output nfa_sr_pkg::out_item_t  result,
  input  wire                    psel,
  input  wire                    penable,
  input  wire                    pwrite,
  input  wire  [2:0]             paddr,
  input  wire  [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]                         st;
  logic [nfa_sr_pkg::NUM_W-1:0]       num_states;
  logic [nfa_sr_pkg::NUM_W-1:0]       n_use;
  logic [nfa_sr_pkg::STATE_W-1:0]     last_state;
  logic [nfa_sr_pkg::STATES-1:0]      active;
  logic                               dead;
  logic [nfa_sr_pkg::DEPTH-1:0]       tv;        // per-entry valid bits
  logic [nfa_sr_pkg::SYM_W-1:0]       sym;
  logic [nfa_sr_pkg::CNT_W-1:0]       cnt;
  logic [nfa_sr_pkg::CNT_W-1:0]       limit;
  logic [nfa_sr_pkg::STATES-1:0]      acc_set;
  logic                               acc_took;
  logic [nfa_sr_pkg::STATES-1:0]      set_next;
  logic                               took_next;
  logic                               hit;
  logic                               p_vld;     // read in flight from an active state
  logic                               p_tv;
  nfa_sr_pkg::tbl_entry_t             rd_q;
  nfa_sr_pkg::tbl_entry_t             mem [nfa_sr_pkg::DEPTH];
  logic [nfa_sr_pkg::ADDR_W-1:0]      waddr;
  logic [nfa_sr_pkg::ADDR_W-1:0]      raddr;
  logic [nfa_sr_pkg::STATE_W-1:0]     scan_state;
  logic                               in_range;
  logic                               accept;
  logic                               wr_en;
  logic                               cfg_wr;

  assign busy   = (st != ST_IDLE);
  assign accept = start && !busy;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Clamp the configured state count into 1..STATES
  always_comb begin
    if (num_states == '0) begin
      n_use = nfa_sr_pkg::NUM_W'(1);
    end else if (num_states > nfa_sr_pkg::NUM_W'(nfa_sr_pkg::STATES)) begin
      n_use = nfa_sr_pkg::NUM_W'(nfa_sr_pkg::STATES);
    end else begin
      n_use = num_states;
    end
  end

  // accepting state; STATES itself wraps to zero in the low bits, giving STATES-1
  assign last_state = n_use[nfa_sr_pkg::STATE_W-1:0] - 1'b1;

  assign limit = nfa_sr_pkg::CNT_W'(n_use) << nfa_sr_pkg::SLOT_W;

  assign in_range = (32'(cmd.entry_state) < nfa_sr_pkg::STATES) &&
                    (32'(cmd.entry_slot) < nfa_sr_pkg::SLOTS);
  assign waddr = {cmd.entry_state[nfa_sr_pkg::STATE_W-1:0],
                  cmd.entry_slot[nfa_sr_pkg::SLOT_W-1:0]};
  assign wr_en = accept && (cmd.opcode == nfa_sr_pkg::OP_WRITE) && in_range;

  assign raddr      = cnt[nfa_sr_pkg::ADDR_W-1:0];
  assign scan_state = raddr[nfa_sr_pkg::ADDR_W-1:nfa_sr_pkg::SLOT_W];

  // Compare stage: entry read last cycle against the symbol
  assign hit       = p_vld && p_tv && (rd_q.symbol == sym);
  assign took_next = acc_took || hit;
  always_comb begin
    set_next = acc_set;
    if (hit && ({1'b0, rd_q.next} < n_use)) begin
      set_next = acc_set |
                 (nfa_sr_pkg::STATES'(1) << rd_q.next[nfa_sr_pkg::STATE_W-1:0]);
    end
  end

  // Transition table RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= '{symbol: cmd.entry_symbol, next: cmd.entry_next};
    end
    rd_q <= mem[raddr];
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      num_states <= nfa_sr_pkg::NUM_STATES_RST;
    end else if (cfg_wr && (paddr[2] == nfa_sr_pkg::REG_NUM_STATES)) begin
      num_states <= pwdata[nfa_sr_pkg::NUM_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == nfa_sr_pkg::REG_NUM_STATES) begin
      prdata = 32'(num_states);
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= ST_IDLE;
      active   <= nfa_sr_pkg::STATES'(1);
      dead     <= 1'b0;
      done     <= 1'b0;
      p_vld    <= 1'b0;
      tv       <= '0;
      acc_took <= 1'b0;
    end else begin
      done <= 1'b0;
      case (st)
        ST_IDLE: begin
          p_vld <= 1'b0;
          if (accept) begin
            case (cmd.opcode)
              nfa_sr_pkg::OP_WRITE: begin
                if (in_range) begin
                  tv[waddr] <= cmd.entry_valid;
                end
                done   <= 1'b1;
                result <= '{moved: 1'b0, alive: !dead, accepted: 1'b0,
                           final_result: 1'b0};
              end
              nfa_sr_pkg::OP_START: begin
                active <= nfa_sr_pkg::STATES'(1);
                dead   <= 1'b0;
                done   <= 1'b1;
                result <= '{moved: 1'b0, alive: 1'b1, accepted: 1'b0,
                           final_result: 1'b0};
              end
              nfa_sr_pkg::OP_FEED: begin
                if (dead) begin
                  done   <= 1'b1;
                  result <= '{moved: 1'b0, alive: 1'b0, accepted: 1'b0,
                             final_result: 1'b0};
                end else begin
                  sym      <= cmd.input_byte;
                  cnt      <= '0;
                  acc_set  <= '0;
                  acc_took <= 1'b0;
                  st       <= ST_SCAN;
                end
              end
              nfa_sr_pkg::OP_END: begin
                done   <= 1'b1;
                result <= '{moved: 1'b0, alive: !dead,
                           accepted: !dead && active[last_state],
                           final_result: 1'b1};
              end
              default: begin
                done <= 1'b0;
              end
            endcase
          end
        end
        ST_SCAN: begin
          p_vld    <= active[scan_state];
          p_tv     <= tv[raddr];
          acc_set  <= set_next;
          acc_took <= took_next;
          cnt      <= cnt + 1'b1;
          if (cnt == limit - 1'b1) begin
            st <= ST_FIN;
          end
        end
        ST_FIN: begin
          // last read lands here; fold it in and retire the symbol
          p_vld  <= 1'b0;
          active <= set_next;
          dead   <= !took_next;
          done   <= 1'b1;
          result <= '{moved: took_next, alive: took_next, accepted: 1'b0,
                     final_result: 1'b0};
          st     <= ST_IDLE;
        end
        default: begin
          st <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (st == ST_SCAN) |-> (cnt < limit))
    else $error("scan counter ran past the table limit");

  a_pipe_only_scan: assert property (@(posedge clk) disable iff (rst)
    p_vld |-> ((st == ST_SCAN) || (st == ST_FIN)))
    else $error("table read in flight outside a scan");

  a_accept_alive: assert property (@(posedge clk) disable iff (rst)
    (done && result.accepted) |-> (result.alive && result.final_result))
    else $error("acceptance reported on a dead string or non-end item");

  a_feed_scans: assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd.opcode == nfa_sr_pkg::OP_FEED) && !dead) |=> (busy && !done))
    else $error("live symbol did not start a table scan");

  a_fin_done: assert property (@(posedge clk) disable iff (rst)
    (st == ST_FIN) |=> (done && !busy))
    else $error("scan finished without a result");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_nfa_string_recognizer_top.sv =====
`default_nettype none

module tb_nfa_string_recognizer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import nfa_sr_pkg::*;

  // Register address: register 0 of the map, byte address 4*0
  localparam logic [2:0] ADDR_NUM_STATES = 3'({REG_NUM_STATES, 2'b00});
  // Longest feed scan (32 states x 8 slots) plus margin
  localparam int SETTLE_CYCLES = 300;
  // Live items per random phase
  localparam int PHASE_ITEMS = 150;

  // ---------------------------------------------------------------------------
  // Clock, reset and block inputs, all known from time zero
  // ---------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  in_item_t    cmd = '0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;

  wire         busy;
  wire         done;
  out_item_t   result;
  wire [31:0]  prdata;
  wire         pready;

  nfa_string_recognizer_top i_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .cmd     (cmd),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Automaton shadow: transition table, active set, dead flag, register
  // ---------------------------------------------------------------------------
  bit                tbl_valid [DEPTH];
  logic [SYM_W-1:0]  tbl_sym   [DEPTH];
  logic [NEXT_W-1:0] tbl_dest  [DEPTH];
  logic [STATES-1:0] live_states = 1;
  bit                string_dead = 1'b0;
  logic [NUM_W-1:0]  nstates_reg = NUM_STATES_RST;

  in_item_t  cmd_backlog[$];       // items waiting to be offered
  out_item_t pending_verdicts[$];  // predicted results, oldest first
  int        live_items = 0;       // accepted items that were not ignored
  int        gap_pct = 19;         // sender idle chance, per cent
  int        n_mismatch = 0;

  // stimulus-side view of the automaton being exercised
  logic [SYM_W-1:0]  alpha [3];
  logic [SYM_W-1:0]  chain_sym [STATES];

  function automatic int clamp_states(logic [NUM_W-1:0] v);
    if (v == 0) return 1;
    if (v > STATES) return STATES;
    return int'(v);
  endfunction

  // Apply one item to the shadow and return the result it must produce.
  // ignored is set for a symbol arriving on a dead string.
  function automatic out_item_t step_automaton(in_item_t it, output bit ignored);
    out_item_t         r;
    int                n;
    int                k;
    logic [STATES-1:0] nxt_set;
    bit                took;
    r = '0;
    ignored = 1'b0;
    n = clamp_states(nstates_reg);
    case (it.opcode)
      OP_WRITE: begin
        if (it.entry_state < STATES && it.entry_slot < SLOTS) begin
          k = int'(it.entry_state) * SLOTS + int'(it.entry_slot);
          tbl_valid[k] = it.entry_valid;
          tbl_sym[k]   = it.entry_symbol;
          tbl_dest[k]  = it.entry_next;
        end
      end
      OP_START: begin
        live_states = 1;
        string_dead = 1'b0;
      end
      OP_FEED: begin
        if (string_dead) begin
          ignored = 1'b1;
        end else begin
          nxt_set = '0;
          took = 1'b0;
          for (int s = 0; s < n; s++) begin
            if (live_states[s]) begin
              for (int j = 0; j < SLOTS; j++) begin
                k = s * SLOTS + j;
                if (tbl_valid[k] && tbl_sym[k] == it.input_byte) begin
                  took = 1'b1;
                  // destinations past num_states count as a move but vanish
                  if (int'(tbl_dest[k]) < n) nxt_set[tbl_dest[k]] = 1'b1;
                end
              end
            end
          end
          live_states = nxt_set;
          if (!took) string_dead = 1'b1;
          r.moved = took;
        end
      end
      default: begin  // OP_END leaves all state alone
        r.final_result = 1'b1;
        r.accepted = !string_dead && live_states[n-1];
      end
    endcase
    r.alive = !string_dead;
    return r;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    n_mismatch++;
    $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers backlog items, predicts each one at the edge it is taken.
  // start/cmd get at most one assignment per edge; start stays high across
  // back-to-back items.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_cmd
    out_item_t want;
    bit        skip;
    if (!rst) begin
      if (start && !busy) begin
        want = step_automaton(cmd, skip);
        pending_verdicts.push_back(want);
        if (!skip) live_items++;
      end
      // load a new item once the current one is taken, or when idle
      if (!start || !busy) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= gap_pct) begin
          start <= 1'b1;
          cmd   <= cmd_backlog.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: done is a one-cycle strobe, compared field by field
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_result
    out_item_t want;
    if (!rst && done === 1'b1) begin
      if (pending_verdicts.size() == 0) begin
        flag_mismatch("result with nothing pending", 32'(result), '0);
      end else begin
        want = pending_verdicts.pop_front();
        if (result.moved !== want.moved)
          flag_mismatch("moved", 32'(result.moved), 32'(want.moved));
        if (result.alive !== want.alive)
          flag_mismatch("alive", 32'(result.alive), 32'(want.alive));
        if (result.accepted !== want.accepted)
          flag_mismatch("accepted", 32'(result.accepted), 32'(want.accepted));
        if (result.final_result !== want.final_result)
          flag_mismatch("final_result", 32'(result.final_result),
                        32'(want.final_result));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers. Don't-care fields of every item carry random bits.
  // ---------------------------------------------------------------------------
  task automatic add_ctl(opcode_t op);
    in_item_t it;
    it = in_item_t'($urandom);
    it.opcode = op;
    cmd_backlog.push_back(it);
  endtask

  task automatic add_feed(logic [SYM_W-1:0] b);
    in_item_t it;
    it = in_item_t'($urandom);
    it.opcode = OP_FEED;
    it.input_byte = b;
    cmd_backlog.push_back(it);
  endtask

  task automatic add_write(int s, int slot, bit v, logic [SYM_W-1:0] sym, int dest);
    in_item_t it;
    it = in_item_t'($urandom);
    it.opcode       = OP_WRITE;
    it.entry_state  = ESTA_W'(s);
    it.entry_slot   = ESLT_W'(slot);
    it.entry_valid  = v;
    it.entry_symbol = sym;
    it.entry_next   = NEXT_W'(dest);
    cmd_backlog.push_back(it);
  endtask

  // mostly symbols of the phase alphabet, now and then any byte
  function automatic logic [SYM_W-1:0] pick_sym();
    if ($urandom_range(9) < 8) return alpha[$urandom_range(2)];
    return SYM_W'($urandom);
  endfunction

  // One stray table write: any state, any slot, any destination
  task automatic add_stray_write(int n);
    int s;
    s = ($urandom_range(3) == 0) ? $urandom_range(STATES-1) : $urandom_range(n-1);
    add_write(s, $urandom_range(SLOTS-1), $urandom_range(3) != 0, pick_sym(),
              ($urandom_range(4) == 0) ? $urandom_range(31) : $urandom_range(n-1));
  endtask

  task automatic wait_idle();
    while (cmd_backlog.size() != 0 || start || pending_verdicts.size() != 0)
      @(posedge clk);
  endtask

  // Register write; lands at the edge with psel, penable, pwrite, pready high
  task automatic apb_write(logic [NUM_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_NUM_STATES;
    pwdata  <= 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    nstates_reg = val;
  endtask

  // New alphabet, some random entries, then a chain 0 -> 1 -> ... -> n-1
  // written last so it survives; walking it gives an accepted string.
  task automatic program_table(int n);
    int slot;
    for (int i = 0; i < 3; i++) alpha[i] = SYM_W'($urandom);
    for (int i = 0; i < n + 4; i++) add_stray_write(n);
    for (int s = 0; s < n - 1; s++) begin
      chain_sym[s] = alpha[$urandom_range(2)];
      slot = $urandom_range(SLOTS-1);
      add_write(s, slot, 1'b1, chain_sym[s], s + 1);
    end
  endtask

  // One string: mostly well-formed with random content, some noise
  task automatic queue_string(int n);
    int kind;
    int len;
    int mut;
    int wr_at;
    kind = $urandom_range(99);
    if ($urandom_range(9) != 0) add_ctl(OP_START);
    if (kind < 35) begin
      // chain walk, sometimes with one symbol swapped
      mut = ($urandom_range(4) == 0) ? $urandom_range(n > 1 ? n - 2 : 0) : -1;
      for (int s = 0; s < n - 1; s++)
        add_feed(s == mut ? pick_sym() : chain_sym[s]);
    end else if (kind < 70) begin
      len = $urandom_range(8);
      for (int i = 0; i < len; i++) add_feed(alpha[$urandom_range(2)]);
    end else if (kind < 80) begin
      len = $urandom_range(4, 1);
      for (int i = 0; i < len; i++) add_feed(SYM_W'($urandom));
    end else begin
      // table rewritten in the middle of a string
      len = $urandom_range(8, 1);
      wr_at = $urandom_range(len - 1);
      for (int i = 0; i < len; i++) begin
        if (i == wr_at) add_stray_write(n);
        add_feed(pick_sym());
      end
    end
    if ($urandom_range(9) != 0) add_ctl(OP_END);
    if ($urandom_range(6) == 0) add_ctl(OP_END);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [NUM_W-1:0] cfg_vals [8];
    int               n;
    int               target;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed, num_states at its reset value of 32
    add_ctl(OP_END);                  // end with no start: state 0 only
    add_feed(8'h00);                  // empty table: string dies
    add_feed(8'hFF);                  // symbol after death, ignored
    add_ctl(OP_END);
    add_ctl(OP_END);                  // repeated end, same verdict
    add_write(0, 0, 1'b1, 8'hFF, 31);
    add_write(31, 7, 1'b1, 8'h00, 0);
    add_write(0, 7, 1'b1, 8'hA5, 0);
    add_write(31, 0, 1'b0, 8'h5A, 31);  // invalid slot, must not match
    add_ctl(OP_START);
    add_feed(8'hFF);                  // straight to the accepting state
    add_ctl(OP_END);
    add_ctl(OP_END);
    add_feed(8'h5A);                  // only the invalid slot carries 5A
    add_ctl(OP_START);
    add_feed(8'hA5);                  // self loop on state 0
    add_write(0, 7, 1'b0, 8'hA5, 0);  // drop it mid-string
    add_feed(8'hA5);                  // now dies
    add_ctl(OP_END);
    add_ctl(OP_START);
    add_feed(8'hFF);
    add_feed(8'h00);                  // back to state 0
    add_ctl(OP_END);
    wait_idle();

    // Random phases: register extremes and clamping, three idling regimes
    cfg_vals = '{6'd1, 6'd63, 6'd0, 6'd32, 6'd5, 6'd33, 6'd2,
                 NUM_W'($urandom_range(31, 3))};
    target = live_items;
    for (int p = 0; p < 8; p++) begin
      gap_pct = (p < 3) ? 19 : (p < 6) ? 68 : 0;
      wait_idle();
      apb_write(cfg_vals[p]);
      n = clamp_states(cfg_vals[p]);
      program_table(n);
      target += PHASE_ITEMS;
      while (live_items < target) begin
        while (cmd_backlog.size() > 6) @(posedge clk);
        queue_string(n);
      end
    end

    // Drain, then give a stray result time to show up
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (n_mismatch == 0 && pending_verdicts.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Hard stop, well past the slowest legal run
  initial begin
    #30_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/nfa_sr_pkg.sv
rtl/nfa_string_recognizer_top.sv
bench/tb_nfa_string_recognizer_top.sv
